FILE: rtl/core/rectified_moving_average_core_assert.svh
// Assertion macros for the rectified moving average core
`ifndef RECTIFIED_MOVING_AVERAGE_CORE_ASSERT_SVH
`define RECTIFIED_MOVING_AVERAGE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RMA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RMA_ASSERT(label, ante, cons, msg)
`define RMA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/rma_pkg.sv
// Shared constants, types and width helpers for the moving average core
`default_nettype none
package rma_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_W           = 7;
  localparam int WINDOW_RESET    = 16;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [0:0] {
    OP_VALUE = 1'b0,
    OP_ZERO  = 1'b1
  } rma_op_t;

  function automatic int win_width(int max_window);
    return $clog2(max_window + 1);
  endfunction

  function automatic int sum_width(int max_window, int sample_bits);
    return sample_bits + $clog2(max_window);
  endfunction

  function automatic int cnt_width(int max_window);
    return $clog2((max_window >> 1) + 1);
  endfunction

  function automatic int cmd_width(int max_window, int sample_bits);
    return 2 + cnt_width(max_window) + sum_width(max_window, sample_bits);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rma_if.sv
// Channel interfaces: sample input, level output and window configuration
`default_nettype none
interface rma_in_if
  import rma_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_in;

  modport source (output valid, sample, last_in, input ready);
  modport sink   (input valid, sample, last_in, output ready);
endinterface

interface rma_out_if
  import rma_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] mean_level;
  logic                   last_out;

  modport source (output valid, mean_level, last_out, input ready);
  modport sink   (input valid, mean_level, last_out, output ready);
endinterface

interface rma_cfg_if
  import rma_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] win_size;

  modport source (output valid, win_size, input ready);
  modport sink   (input valid, win_size, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rma_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module rma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // read-first: a read and write to the same address return the old word
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/rma_queue.sv
// Short command queue between the front and back ends
`default_nettype none
module rma_queue
  import rma_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
`include "rectified_moving_average_core_assert.svh"

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  `RMA_ASSERT(a_queue_count_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "queue count past depth")

endmodule
`default_nettype wire

FILE: rtl/core/rma_front.sv
// Front end: rectify, delay line, running sum and output classification
`default_nettype none
module rma_front
  import rma_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int WIN_W = win_width(MAX_WINDOW),
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int SUM_W = sum_width(MAX_WINDOW, SAMPLE_BITS),
  localparam int N_W = cnt_width(MAX_WINDOW),
  localparam int CMD_W = cmd_width(MAX_WINDOW, SAMPLE_BITS)
) (
  input  logic             clk,
  input  logic             rst_n,
  rma_in_if.sink           in_ch,
  input  logic [WIN_W-1:0] win,
  input  logic             clear,
  output logic             q_push,
  output logic [CMD_W-1:0] q_data,
  input  logic             q_full
);
`include "rectified_moving_average_core_assert.svh"

  typedef struct packed {
    rma_op_t          op;
    logic             last;
    logic [N_W-1:0]   n;
    logic [SUM_W-1:0] sum;
  } cmd_t;

  logic [WIN_W-1:0]       half;
  logic [WIN_W-1:0]       twoh;
  logic                   accept;
  logic [SAMPLE_BITS-1:0] mag;
  logic [WIN_W:0]         slot_ext;
  logic [WIN_W:0]         diff;
  logic [SLOT_W-1:0]      old_slot;
  logic [WIN_W-1:0]       cnt_inc;
  logic [SAMPLE_BITS-1:0] rd_data;

  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [WIN_W-1:0]       count_r, count_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;

  logic                   b_valid_r;
  logic [SAMPLE_BITS-1:0] b_mag_r;
  logic                   b_last_r;
  logic [WIN_W-1:0]       b_count_r;
  logic                   b_old_ok_r;

  logic [SAMPLE_BITS-1:0] old_mag;
  logic [SUM_W-1:0]       sum_upd;
  logic                   need_push;
  logic                   b_go;
  cmd_t                   cmd;

  assign half = win >> 1;
  assign twoh = {half[WIN_W-2:0], 1'b0};

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !b_valid_r || b_go;

  assign mag = in_ch.sample[SAMPLE_BITS-1]
             ? SAMPLE_BITS'(~in_ch.sample) + SAMPLE_BITS'(1)
             : SAMPLE_BITS'(in_ch.sample);

  // slot that drops out of the window: write slot minus twice half, modulo depth
  assign slot_ext = (WIN_W + 1)'(slot_r);
  assign diff = (slot_ext >= (WIN_W + 1)'(twoh))
              ? slot_ext - (WIN_W + 1)'(twoh)
              : slot_ext + (WIN_W + 1)'(MAX_WINDOW) - (WIN_W + 1)'(twoh);
  assign old_slot = diff[SLOT_W-1:0];

  assign cnt_inc = (count_r < win) ? count_r + WIN_W'(1) : count_r;

  rma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_line (
    .clk   (clk),
    .we    (accept),
    .waddr (slot_r),
    .wdata (mag),
    .re    (accept),
    .raddr (old_slot),
    .rdata (rd_data)
  );

  always_comb begin
    slot_nxt  = slot_r;
    count_nxt = count_r;
    if (clear) begin
      slot_nxt  = '0;
      count_nxt = '0;
    end else if (accept) begin
      if (in_ch.last_in) begin
        slot_nxt  = '0;
        count_nxt = '0;
      end else begin
        slot_nxt  = (slot_r == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
        count_nxt = cnt_inc;
      end
    end
  end

  // entries older than this stream read as zero
  assign old_mag   = b_old_ok_r ? rd_data : '0;
  assign sum_upd   = sum_r - SUM_W'(old_mag) + SUM_W'(b_mag_r);
  assign need_push = b_last_r || (b_count_r >= half);
  assign b_go      = b_valid_r && (!need_push || !q_full);
  assign q_push    = b_go && need_push;
  assign q_data    = CMD_W'(cmd);

  always_comb begin
    cmd.sum = sum_upd;
    if (b_last_r) begin
      cmd.op   = OP_ZERO;
      cmd.last = 1'b1;
      cmd.n    = (b_count_r < half) ? N_W'(b_count_r) : N_W'(half);
    end else if (b_count_r >= twoh) begin
      cmd.op   = OP_VALUE;
      cmd.last = 1'b0;
      cmd.n    = '0;
    end else begin
      cmd.op   = OP_ZERO;
      cmd.last = 1'b0;
      cmd.n    = N_W'(1);
    end
  end

  always_comb begin
    sum_nxt = sum_r;
    if (clear) begin
      sum_nxt = '0;
    end else if (b_go) begin
      sum_nxt = b_last_r ? '0 : sum_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      count_r   <= '0;
      sum_r     <= '0;
      b_valid_r <= 1'b0;
    end else begin
      slot_r  <= slot_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      if (in_ch.ready) begin
        b_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_mag_r    <= mag;
      b_last_r   <= in_ch.last_in;
      b_count_r  <= cnt_inc;
      b_old_ok_r <= (count_r >= twoh);
    end
  end

  `RMA_ASSERT(a_count_within_window, 1'b1, count_r <= win, "sample count past window")
  `RMA_ASSERT_NEXT(a_sum_cleared_at_end, b_go && b_last_r, sum_r == '0, "sum kept after last")

endmodule
`default_nettype wire

FILE: rtl/core/rma_back.sv
// Back end: bit-serial divide by the window and zero-result flush
`default_nettype none
module rma_back
  import rma_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int WIN_W = win_width(MAX_WINDOW),
  localparam int SUM_W = sum_width(MAX_WINDOW, SAMPLE_BITS),
  localparam int N_W = cnt_width(MAX_WINDOW),
  localparam int CMD_W = cmd_width(MAX_WINDOW, SAMPLE_BITS),
  localparam int STEP_W = $clog2(SAMPLE_BITS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [WIN_W-1:0] win,
  input  logic             q_empty,
  input  logic [CMD_W-1:0] q_data,
  output logic             q_pop,
  rma_out_if.source        out_ch
);
`include "rectified_moving_average_core_assert.svh"

  typedef struct packed {
    rma_op_t          op;
    logic             last;
    logic [N_W-1:0]   n;
    logic [SUM_W-1:0] sum;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_DONE = 4'b0100,
    ST_ZERO = 4'b1000
  } st_t;

  cmd_t                   cmd;
  st_t                    st_r, st_nxt;
  logic [WIN_W-1:0]       rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] dvd_r, dvd_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [N_W-1:0]         zcnt_r, zcnt_nxt;
  logic                   zlast_r, zlast_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_mean_r, out_mean_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   out_free;
  logic [WIN_W:0]         trial;
  logic                   fits;
  logic [WIN_W-1:0]       rem_step;
  logic [SAMPLE_BITS-1:0] dvd_step;

  assign cmd = cmd_t'(q_data);

  assign out_free          = !out_valid_r || out_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.mean_level = out_mean_r;
  assign out_ch.last_out   = out_last_r;

  // restoring division, one quotient bit per cycle; remainder stays below the window
  assign trial    = {rem_r, dvd_r[SAMPLE_BITS-1]};
  assign fits     = (trial >= {1'b0, win});
  assign rem_step = fits ? WIN_W'(trial - {1'b0, win}) : trial[WIN_W-1:0];
  assign dvd_step = {dvd_r[SAMPLE_BITS-2:0], fits};

  always_comb begin
    st_nxt        = st_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    step_nxt      = step_r;
    zcnt_nxt      = zcnt_r;
    zlast_nxt     = zlast_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_mean_nxt  = out_mean_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (cmd.op)
            OP_VALUE: begin
              rem_nxt  = WIN_W'(cmd.sum[SUM_W-1:SAMPLE_BITS]);
              dvd_nxt  = cmd.sum[SAMPLE_BITS-1:0];
              step_nxt = STEP_W'(SAMPLE_BITS);
              st_nxt   = ST_DIV;
            end
            OP_ZERO: begin
              zcnt_nxt  = cmd.n;
              zlast_nxt = cmd.last;
              st_nxt    = ST_ZERO;
            end
            default: st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        rem_nxt  = rem_step;
        dvd_nxt  = dvd_step;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = dvd_r;
          out_last_nxt  = 1'b0;
          st_nxt        = ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = '0;
          out_last_nxt  = zlast_r && (zcnt_r == N_W'(1));
          zcnt_nxt      = zcnt_r - N_W'(1);
          if (zcnt_r == N_W'(1)) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    step_r     <= step_nxt;
    zcnt_r     <= zcnt_nxt;
    zlast_r    <= zlast_nxt;
    out_mean_r <= out_mean_nxt;
    out_last_r <= out_last_nxt;
  end

  `RMA_ASSERT(a_rem_below_window, st_r == ST_DIV, rem_r < win, "remainder not below window")
  `RMA_ASSERT(a_zero_count_live, st_r == ST_ZERO, zcnt_r != '0, "zero flush with no count")

endmodule
`default_nettype wire

FILE: rtl/core/rectified_moving_average_core.sv
// Top level of the rectified centred moving-average envelope core
//
// Channels: in_ch takes signed samples with a last flag, out_ch gives the
// mean magnitude level with a last flag, cfg_ch writes the window length
// (clamped to 2..MAX_WINDOW; a write restarts the stream). All are
// valid/ready, a transfer happens when both are high.
// Result i of a stream leaves once sample i+half-1 has been taken; the first
// half and last half results are zero, and the last sample flushes them.
// An averaged result passes the input register, the command queue, the
// bit-serial divider and the output register; a zero result skips the divider.
// Throughput: samples that raise no result go at one per cycle; the back end
// takes no new command until the bit-serial divider has finished the last
// averaged result; flushed zeros come at one per cycle while out_ch.ready is high.
// A four-entry command queue between front and back end keeps the input
// moving while the output stalls; once it fills, in_ch.ready drops.
// Reset: window 16, empty stream, no result pending; the delay line needs
// no clearing pass.
`default_nettype none
module rectified_moving_average_core
  import rma_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rma_cfg_if.sink   cfg_ch,
  rma_in_if.sink    in_ch,
  rma_out_if.source out_ch
);

  localparam int WIN_W   = win_width(MAX_WINDOW);
  localparam int CMD_W   = cmd_width(MAX_WINDOW, SAMPLE_BITS);
  localparam int WIN_RST = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

  logic [WIN_W-1:0] win_r, win_nxt;
  logic [WIN_W-1:0] win_cfg;
  logic             cfg_wr;
  logic             q_push;
  logic [CMD_W-1:0] q_wdata;
  logic             q_full;
  logic             q_pop;
  logic [CMD_W-1:0] q_rdata;
  logic             q_empty;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    if (32'(cfg_ch.win_size) < 32'(2)) begin
      win_cfg = WIN_W'(2);
    end else if (32'(cfg_ch.win_size) > 32'(MAX_WINDOW)) begin
      win_cfg = WIN_W'(MAX_WINDOW);
    end else begin
      win_cfg = WIN_W'(cfg_ch.win_size);
    end
  end

  assign win_nxt = cfg_wr ? win_cfg : win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_W'(WIN_RST);
    end else begin
      win_r <= win_nxt;
    end
  end

  rma_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .win    (win_r),
    .clear  (cfg_wr),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  rma_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  rma_back #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .win     (win_r),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench for the rectified moving average core: directed table then random streams
`default_nettype none
module tb
  import rma_pkg::*;
;

  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int MAXW        = MAX_WINDOW_DEF;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE      = SB + 14;
  localparam int ITEM_TARGET = 270;
  localparam int PREDICTED   = -1;
  localparam int SQUEEZE_LEN = 400;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    logic [SB-1:0] level;
    logic          tail;
  } level_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_W-1:0]       win;
    logic signed [SB-1:0]   smp;
    logic                   lst;
    int                     n_typed;
    logic [SB-1:0]          typed_level;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rma_cfg_if cfg_ch ();
  rma_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  rma_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  rectified_moving_average_core #(
    .MAX_WINDOW (MAXW),
    .SAMPLE_BITS(SB)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // envelope predictor state
  logic [SB-1:0]    mag_line [MAXW];
  logic [SB+5:0]    mag_sum;
  logic [5:0]       line_slot;
  logic [6:0]       stream_seen;
  logic [CFG_W-1:0] window_setting;

  level_t pending_levels[$];
  level_t step_levels[$];

  int  errors = 0;
  int  cycles = 0;
  int  items_sent = 0;
  bit  steady = 1'b0;
  logic squeeze_req = 1'b0;
  logic squeezed;
  int  stall_left;
  int  rx_hold;

  dir_row_t dir_rows [22] = '{
    '{ROW_SAMPLE, 7'd0,   16'sh7fff, 1'b0, 0,         16'h0000},
    '{ROW_SAMPLE, 7'd0,   16'sh8000, 1'b1, 2,         16'h0000},
    '{ROW_CFG,    7'd0,   16'sh0000, 1'b0, 0,         16'h0000},
    '{ROW_SAMPLE, 7'd0,   16'sh8000, 1'b1, 1,         16'h0000},
    '{ROW_SAMPLE, 7'd0,   16'sh8000, 1'b0, 1,         16'h0000},
    '{ROW_SAMPLE, 7'd0,   16'sh8000, 1'b0, 1,         16'h8000},
    '{ROW_SAMPLE, 7'd0,   16'sh7fff, 1'b0, 1,         16'h7fff},
    '{ROW_SAMPLE, 7'd0,   16'sh0000, 1'b1, 1,         16'h0000},
    '{ROW_CFG,    7'd127, 16'sh0000, 1'b0, 0,         16'h0000},
    '{ROW_SAMPLE, 7'd0,   16'sh0001, 1'b0, 0,         16'h0000},
    '{ROW_SAMPLE, 7'd0,   16'shffff, 1'b0, 0,         16'h0000},
    '{ROW_SAMPLE, 7'd0,   16'sh0005, 1'b1, 3,         16'h0000},
    '{ROW_CFG,    7'd5,   16'sh0000, 1'b0, 0,         16'h0000},
    '{ROW_SAMPLE, 7'd0,   16'sd100,  1'b0, PREDICTED, 16'h0000},
    '{ROW_SAMPLE, 7'd0,   -16'sd200, 1'b0, PREDICTED, 16'h0000},
    '{ROW_SAMPLE, 7'd0,   16'sd300,  1'b0, PREDICTED, 16'h0000},
    '{ROW_SAMPLE, 7'd0,   -16'sd400, 1'b0, PREDICTED, 16'h0000},
    '{ROW_SAMPLE, 7'd0,   16'sh7fff, 1'b0, PREDICTED, 16'h0000},
    '{ROW_CFG,    7'd3,   16'sh0000, 1'b0, 0,         16'h0000},
    '{ROW_SAMPLE, 7'd0,   16'sd9,    1'b0, PREDICTED, 16'h0000},
    '{ROW_SAMPLE, 7'd0,   -16'sd9,   1'b0, PREDICTED, 16'h0000},
    '{ROW_SAMPLE, 7'd0,   16'sd1,    1'b1, PREDICTED, 16'h0000}
  };

  function automatic void clear_stream_state();
    for (int i = 0; i < MAXW; i++) mag_line[i] = '0;
    mag_sum     = '0;
    line_slot   = '0;
    stream_seen = '0;
  endfunction

  function automatic logic [6:0] eff_window();
    if (window_setting < 2) return 7'd2;
    if (window_setting > MAXW) return 7'(MAXW);
    return window_setting;
  endfunction

  function automatic logic [SB-1:0] magnitude(input logic signed [SB-1:0] s);
    return s[SB-1] ? (~s + 1'b1) : s;
  endfunction

  function automatic void predict_levels(input logic signed [SB-1:0] smp, input logic lst);
    logic [6:0]    w;
    logic [6:0]    half;
    logic [6:0]    twoh;
    logic [6:0]    k;
    logic [5:0]    old_slot;
    logic [SB-1:0] m;
    level_t        lv;
    w        = eff_window();
    half     = w >> 1;
    twoh     = half << 1;
    m        = magnitude(smp);
    old_slot = line_slot - twoh[5:0];
    mag_sum  = mag_sum - (SB+6)'(mag_line[old_slot]) + (SB+6)'(m);
    mag_line[line_slot] = m;
    line_slot++;
    if (stream_seen < w) stream_seen++;
    step_levels.delete();
    if (lst) begin
      k = (stream_seen < half) ? stream_seen : half;
      for (int r = 0; r < k; r++) begin
        lv.level = '0;
        lv.tail  = (r == k - 1);
        step_levels.push_back(lv);
      end
      clear_stream_state();
    end else if (stream_seen >= half) begin
      lv.level = (stream_seen >= twoh) ? SB'(mag_sum / (SB+6)'(w)) : '0;
      lv.tail  = 1'b0;
      step_levels.push_back(lv);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SB-1:0] rand_sample();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return 16'sh0000;
        3: return 16'shffff;
        default: return 16'sh0001;
      endcase
    end
    return SB'($urandom());
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    $display("cycle %0d: %s mismatch, got %0d, expected %0d", cycles, field, got, want);
  endtask

  task automatic check_level();
    level_t lv;
    if (pending_levels.size() == 0) begin
      report_mismatch("unexpected level", out_ch.mean_level, -1);
    end else begin
      lv = pending_levels.pop_front();
      if (out_ch.mean_level !== lv.level)
        report_mismatch("mean_level", out_ch.mean_level, lv.level);
      if (out_ch.last_out !== lv.tail)
        report_mismatch("last_out", out_ch.last_out, lv.tail);
    end
  endtask

  task automatic send_sample(input logic signed [SB-1:0] smp, input logic lst,
                             input int n_typed, input logic [SB-1:0] typed_level);
    int     gap;
    level_t lv;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= smp;
    in_ch.last_in <= lst;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    predict_levels(smp, lst);
    if (n_typed == PREDICTED) begin
      foreach (step_levels[i]) pending_levels.push_back(step_levels[i]);
    end else begin
      for (int r = 0; r < n_typed; r++) begin
        lv.level = typed_level;
        lv.tail  = lst && (r == n_typed - 1);
        pending_levels.push_back(lv);
      end
    end
  endtask

  // only while idle: all results in, then room for a zero-result sample to drain
  task automatic write_window(input logic [CFG_W-1:0] w);
    in_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.win_size <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    window_setting = w;
    clear_stream_state();
  endtask

  task automatic run_stream(input int len, input bit open_end);
    for (int i = 0; i < len; i++)
      send_sample(rand_sample(), (i == len - 1) && !open_end, PREDICTED, '0);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] w, input int n_streams,
                           input bit open_end);
    int half;
    int len;
    write_window(w);
    half = eff_window() >> 1;
    for (int s = 0; s < n_streams; s++) begin
      if ($urandom_range(0, 3) != 0)
        len = $urandom_range(2 * half, 2 * half + 12);
      else
        len = $urandom_range(1, 2 * half);
      run_stream(len, open_end && (s == n_streams - 1));
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // long receiver hold-off to back the block up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      squeezed   <= 1'b0;
    end else if (squeeze_req && !squeezed) begin
      stall_left <= SQUEEZE_LEN;
      squeezed   <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_hold      <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_level();
      if (stall_left != 0 || rx_hold != 0) begin
        out_ch.ready <= 1'b0;
        if (rx_hold != 0) rx_hold <= rx_hold - 1;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        rx_hold      <= pick_gap();
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] w;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.sample    <= '0;
    in_ch.last_in   <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.win_size <= '0;
    window_setting = 7'(WINDOW_RESET);
    clear_stream_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_window(dir_rows[i].win);
      else
        send_sample(dir_rows[i].smp, dir_rows[i].lst, dir_rows[i].n_typed,
                    dir_rows[i].typed_level);
    end

    // widest window, long enough to average and to flush the full half
    steady = 1'b0;
    run_phase(7'd127, 0, 1'b0);
    run_stream(70, 1'b0);

    // narrow window under a long receiver stall
    steady = 1'b1;
    write_window(7'd3);
    squeeze_req <= 1'b1;
    run_stream(40, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 6))
          0: w = 7'd0;
          1: w = 7'd1;
          2: w = 7'd2;
          3: w = 7'd63;
          4: w = 7'd64;
          5: w = 7'd65;
          default: w = 7'd127;
        endcase
      end else begin
        w = 7'($urandom_range(2, 12));
      end
      run_phase(w, (w > 16) ? 1 : $urandom_range(1, 3), $urandom_range(0, 3) == 0);
    end

    in_ch.valid <= 1'b0;
    steady = 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
